// File: src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/u16u8_pkg.sv
package u16u8_pkg;

  // UTF-16 code unit classes (upper six bits)
  localparam logic [5:0] SURR_LEAD  = 6'b110110;
  localparam logic [5:0] SURR_TRAIL = 6'b110111;

  // UTF-8 prefix bytes
  localparam logic [7:0] PFX_FOUR  = 8'hF0;
  localparam logic [7:0] PFX_THREE = 8'hE0;
  localparam logic [7:0] PFX_TWO   = 8'hC0;
  localparam logic [7:0] PFX_CONT  = 8'h80;

  // Offset of supplementary code points
  localparam logic [20:0] SUPP_BASE = 21'h010000;

  localparam int unsigned MAX_BYTES = 4;
  localparam int unsigned IDX_W     = $clog2(MAX_BYTES);

  // One input item as held in the input register
  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } unit_t;

  // Bytes produced for one item, first byte in slot 0
  typedef struct packed {
    logic                           nonempty;
    logic [IDX_W-1:0]               last_idx;
    logic [MAX_BYTES-1:0][7:0]      bytes;
  } grp_t;

endpackage

// File: src/u16u8_if.sv
// Code unit channel
interface u16u8_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_string;

  modport source (output valid, output code_unit, output end_of_string, input ready);
  modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

// Byte channel
interface u16u8_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] utf8_byte;
  logic       last_byte;

  modport source (output valid, output utf8_byte, output last_byte, input ready);
  modport sink   (input valid, input utf8_byte, input last_byte, output ready);
endinterface

// File: src/u16u8_in_reg.sv
module u16u8_in_reg
  import u16u8_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  unit_t in_item,
  input  logic  adv,
  output logic  vld,
  output unit_t item
);

  logic  vld_r;
  logic  vld_nxt;
  unit_t item_r;

  // Slot frees when the held item moves on this cycle
  assign in_ready = !vld_r || adv;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && in_ready) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

// File: src/u16u8_encode.sv
module u16u8_encode
  import u16u8_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  unit_t item,
  input  logic  adv,
  output grp_t  grp
);

  logic        pend_r;
  logic        pend_nxt;
  logic [9:0]  lead_r;
  logic [9:0]  lead_nxt;
  logic [5:0]  kind;
  logic [15:0] u;
  logic [20:0] cp;

  assign u    = item.code_unit;
  assign kind = u[15:10];
  assign cp   = SUPP_BASE + {1'b0, lead_r, u[9:0]};

  // Byte group for the current unit
  always_comb begin
    grp = '0;
    priority if (pend_r) begin
      if (kind == SURR_TRAIL) begin
        grp.nonempty = 1'b1;
        grp.last_idx = IDX_W'(3);
        grp.bytes[0] = PFX_FOUR | {5'b0, cp[20:18]};
        grp.bytes[1] = PFX_CONT | {2'b0, cp[17:12]};
        grp.bytes[2] = PFX_CONT | {2'b0, cp[11:6]};
        grp.bytes[3] = PFX_CONT | {2'b0, cp[5:0]};
      end
    end else if (kind == SURR_LEAD || kind == SURR_TRAIL) begin
      grp.nonempty = 1'b0;
    end else if (u[15:7] == '0) begin
      grp.nonempty = 1'b1;
      grp.last_idx = IDX_W'(0);
      grp.bytes[0] = u[7:0];
    end else if (u[15:11] == '0) begin
      grp.nonempty = 1'b1;
      grp.last_idx = IDX_W'(1);
      grp.bytes[0] = PFX_TWO  | {3'b0, u[10:6]};
      grp.bytes[1] = PFX_CONT | {2'b0, u[5:0]};
    end else begin
      grp.nonempty = 1'b1;
      grp.last_idx = IDX_W'(2);
      grp.bytes[0] = PFX_THREE | {4'b0, u[15:12]};
      grp.bytes[1] = PFX_CONT  | {2'b0, u[11:6]};
      grp.bytes[2] = PFX_CONT  | {2'b0, u[5:0]};
    end
  end

  // Held leading surrogate
  always_comb begin
    pend_nxt = pend_r;
    lead_nxt = lead_r;
    if (adv) begin
      if (pend_r) begin
        pend_nxt = 1'b0;
        lead_nxt = '0;
      end else if (kind == SURR_LEAD) begin
        pend_nxt = 1'b1;
        lead_nxt = u[9:0];
      end
      if (item.end_of_string) begin
        pend_nxt = 1'b0;
        lead_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      lead_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      lead_r <= lead_nxt;
    end
  end

endmodule

// File: src/u16u8_serial.sv
module u16u8_serial
  import u16u8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  grp_t       grp_in,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic             vld_r;
  logic             vld_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  grp_t             grp_r;
  logic             fire;

  assign out_valid = vld_r;
  assign out_byte  = grp_r.bytes[idx_r];
  assign out_last  = (idx_r == grp_r.last_idx);
  assign fire      = vld_r && out_ready;
  assign free      = !vld_r || (fire && out_last);

  // Byte index walks the group, reloads on a new group
  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (load) begin
      vld_nxt = 1'b1;
      idx_nxt = '0;
    end else if (fire && out_last) begin
      vld_nxt = 1'b0;
      idx_nxt = '0;
    end else if (fire) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_in;
    end
  end

endmodule

// File: src/utf16_to_utf8_encoder_top.sv
// Channel   Dir  Payload                          Handshake
// in_ch     in   code_unit[15:0], end_of_string   valid/ready
// out_ch    out  utf8_byte[7:0], last_byte        valid/ready
//
// One code unit enters per cycle while the byte register is free; each byte
// leaves one per cycle while out_ch is ready, so an item occupies the byte
// register until its last byte leaves. Lead surrogates and dropped units emit
// nothing; other units pass the input register and then the byte register.
// Synchronous active-low reset clears the valid flags and the held surrogate.
// Under out_ch stall the input register still takes one more item.
module utf16_to_utf8_encoder_top
  import u16u8_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  u16u8_unit_if.sink   in_ch,
  u16u8_byte_if.source out_ch
);

  unit_t in_item;
  unit_t item;
  grp_t  grp;
  logic  in_vld;
  logic  adv;
  logic  free;
  logic  load;

  assign in_item.code_unit     = in_ch.code_unit;
  assign in_item.end_of_string = in_ch.end_of_string;

  // Item moves on when it emits nothing or the byte register frees up
  assign adv  = in_vld && (!grp.nonempty || free);
  assign load = adv && grp.nonempty;

  u16u8_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_item),
    .adv      (adv),
    .vld      (in_vld),
    .item     (item)
  );

  u16u8_encode u_enc (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .adv   (adv),
    .grp   (grp)
  );

  u16u8_serial u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .grp_in    (grp),
    .free      (free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_byte  (out_ch.utf8_byte),
    .out_last  (out_ch.last_byte)
  );

endmodule

// File: src/u16u8_checker.sv
`include "assert_macros.svh"

module u16u8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // Stalled byte holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last))

  // A non-final byte is always followed at once by a continuation byte
  `ASSERT_NEXT(a_cont_follows, clk, rst_n, out_valid && out_ready && !out_last, out_valid && out_byte[7:6] == 2'b10)

  // A lead byte never ends an item
  `ASSERT_IMPLY(a_lead_not_last, clk, rst_n, out_valid && out_byte[7:6] == 2'b11, !out_last)

  // An ASCII byte is always a whole item
  `ASSERT_IMPLY(a_ascii_last, clk, rst_n, out_valid && !out_byte[7], out_last)

endmodule

bind utf16_to_utf8_encoder_top u16u8_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.utf8_byte),
  .out_last  (out_ch.last_byte)
);
